FILE: rtl/core/pointer_event_qualifier_macros.svh
// ----------------------------------------------------------------------------
// pointer_event_qualifier_macros.svh
// Assertion helpers for the pointer event qualifier; empty in synthesis.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni in the scope of the module using it.
`ifndef POINTER_EVENT_QUALIFIER_MACROS_SVH
`define POINTER_EVENT_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked every cycle outside reset.
`define PEVQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pevq check failed");

// Same-cycle implication.
`define PEVQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pevq check failed");

// Next-cycle implication.
`define PEVQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pevq check failed");

`else

`define PEVQ_ASSERT(lbl, prop)
`define PEVQ_ASSERT_SAME(lbl, ante, cons)
`define PEVQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/pevq_pkg.sv
// ----------------------------------------------------------------------------
// pevq_pkg
// Shared types, constants and helpers of the pointer event qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pevq_pkg;

  localparam int unsigned POS_W        = 16;
  localparam int unsigned SCREEN_W     = 15;
  localparam int unsigned CURSOR_W     = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 15;
  localparam int unsigned DISCARD_W    = 4;
  localparam int unsigned NUM_BTN      = 3;
  // one move slot plus one slot per button
  localparam int unsigned NUM_SLOTS    = 4;
  localparam int unsigned SLOT_IDX_W   = 2;

  localparam int unsigned DISCARD_EVENTS_DEF = 8;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 15'd1024;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 15'd768;
  localparam logic [CURSOR_W-1:0] CURSOR_WIDTH_RST  = 8'd16;
  localparam logic [CURSOR_W-1:0] CURSOR_HEIGHT_RST = 8'd16;

  // button bit positions in the held mask, also the service order
  localparam logic [1:0] BTN_CENTER = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_LEFT   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IGNORE_POINTER = 3'd0,
    CFG_SCREEN_WIDTH   = 3'd1,
    CFG_SCREEN_HEIGHT  = 3'd2,
    CFG_CURSOR_WIDTH   = 3'd3,
    CFG_CURSOR_HEIGHT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    EV_MOVE        = 4'd0,
    EV_CENTER_DOWN = 4'd1,
    EV_CENTER_DRAG = 4'd2,
    EV_CENTER_UP   = 4'd3,
    EV_RIGHT_DOWN  = 4'd4,
    EV_RIGHT_DRAG  = 4'd5,
    EV_RIGHT_UP    = 4'd6,
    EV_LEFT_DOWN   = 4'd7,
    EV_LEFT_DRAG   = 4'd8,
    EV_LEFT_UP     = 4'd9
  } event_kind_e;

  typedef enum logic [1:0] {
    ACT_DOWN = 2'd0,
    ACT_DRAG = 2'd1,
    ACT_UP   = 2'd2
  } btn_act_e;

  typedef struct packed {
    logic                ignore_pointer;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [CURSOR_W-1:0] cursor_width;
    logic [CURSOR_W-1:0] cursor_height;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    button_left;
    logic                    button_right;
    logic                    button_center;
  } report_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } point_t;

  typedef struct packed {
    event_kind_e kind;
    point_t      anchor;
  } result_t;

  // all results of one report; slot 0 is the move, slots 1..3 the buttons
  typedef struct packed {
    logic [NUM_SLOTS-1:0]  mask;
    point_t                cursor;
    result_t [NUM_SLOTS-1:0] slot;
  } batch_t;

  function automatic event_kind_e button_kind(logic [1:0] btn, btn_act_e act);
    event_kind_e k;
    k = EV_MOVE;
    case (btn)
      BTN_CENTER: begin
        case (act)
          ACT_DOWN: k = EV_CENTER_DOWN;
          ACT_DRAG: k = EV_CENTER_DRAG;
          default:  k = EV_CENTER_UP;
        endcase
      end
      BTN_RIGHT: begin
        case (act)
          ACT_DOWN: k = EV_RIGHT_DOWN;
          ACT_DRAG: k = EV_RIGHT_DRAG;
          default:  k = EV_RIGHT_UP;
        endcase
      end
      default: begin
        case (act)
          ACT_DOWN: k = EV_LEFT_DOWN;
          ACT_DRAG: k = EV_LEFT_DRAG;
          default:  k = EV_LEFT_UP;
        endcase
      end
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pevq_cfg_regs.sv
// ----------------------------------------------------------------------------
// pevq_cfg_regs
// Configuration register file, written through a valid/ready request port.
// ----------------------------------------------------------------------------
`default_nettype none

module pevq_cfg_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [pevq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [pevq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output      pevq_pkg::cfg_t                       cfg_o
);

  pevq_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ignore_pointer <= 1'b0;
      cfg_q.screen_width   <= pevq_pkg::SCREEN_WIDTH_RST;
      cfg_q.screen_height  <= pevq_pkg::SCREEN_HEIGHT_RST;
      cfg_q.cursor_width   <= pevq_pkg::CURSOR_WIDTH_RST;
      cfg_q.cursor_height  <= pevq_pkg::CURSOR_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (pevq_pkg::cfg_reg_e'(cfg_index_i))
        pevq_pkg::CFG_IGNORE_POINTER: cfg_q.ignore_pointer <= cfg_data_i[0];
        pevq_pkg::CFG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_data_i;
        pevq_pkg::CFG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_data_i;
        pevq_pkg::CFG_CURSOR_WIDTH:   cfg_q.cursor_width   <= cfg_data_i[7:0];
        pevq_pkg::CFG_CURSOR_HEIGHT:  cfg_q.cursor_height  <= cfg_data_i[7:0];
        default: ; // unmapped index, dropped
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pevq_engine.sv
// ----------------------------------------------------------------------------
// pevq_engine
// Input register plus the cursor / button state; resolves one report per
// cycle, while the result queue is free, into a batch of up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pointer_event_qualifier_macros.svh"

module pevq_engine #(
  parameter int unsigned DISCARD_EVENTS = pevq_pkg::DISCARD_EVENTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pevq_pkg::cfg_t    cfg_i,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire pevq_pkg::report_t req_i,
  input  wire logic              free_i,
  output      logic              load_o,
  output      pevq_pkg::batch_t  batch_o
);

  localparam int unsigned DiscardW = pevq_pkg::DISCARD_W;
  localparam int unsigned PosW     = pevq_pkg::POS_W;

  logic                        in_valid_q;
  pevq_pkg::report_t           req_q;
  logic signed [PosW-1:0]      cur_x_q, cur_y_q, cur_z_q;
  pevq_pkg::point_t            anchor_q;
  logic [pevq_pkg::NUM_BTN-1:0] held_q;
  logic [DiscardW-1:0]         discard_q;

  logic                        fire;
  logic                        commit;
  logic                        moved;
  logic                        window;
  logic [pevq_pkg::NUM_BTN-1:0] btn;
  logic [pevq_pkg::NUM_BTN-1:0] held_d;
  logic [DiscardW-1:0]         discard_d;
  pevq_pkg::point_t            cur_d;
  pevq_pkg::point_t            anchor_d;
  pevq_pkg::btn_act_e          act;

  // Low bound first, then the high bound; a negative high bound wins.
  function automatic logic signed [PosW-1:0] clamp_axis(
    logic signed [PosW-1:0]           v,
    logic [pevq_pkg::SCREEN_W-1:0]    scr,
    logic [pevq_pkg::CURSOR_W-1:0]    cur
  );
    logic signed [PosW:0] hi;
    logic signed [PosW:0] vx;
    hi = $signed({2'b00, scr}) - $signed({9'b0, cur}) - 17'sd1;
    vx = {v[PosW-1], v};
    if (vx < 17'sd0) vx = 17'sd0;
    if (vx > hi)     vx = hi;
    return vx[PosW-1:0];
  endfunction

  assign fire       = in_valid_q && (free_i || cfg_i.ignore_pointer);
  assign commit     = fire && !cfg_i.ignore_pointer;
  assign in_ready_o = !in_valid_q || fire;
  assign load_o     = commit && (batch_o.mask != '0);

  always_comb begin
    btn    = {req_q.button_left, req_q.button_right, req_q.button_center};
    moved  = (cur_x_q != req_q.pos_x) || (cur_y_q != req_q.pos_y);
    window = (discard_q != '0);

    cur_d.x = moved ? clamp_axis(req_q.pos_x, cfg_i.screen_width, cfg_i.cursor_width)
                    : cur_x_q;
    cur_d.y = moved ? clamp_axis(req_q.pos_y, cfg_i.screen_height, cfg_i.cursor_height)
                    : cur_y_q;
    cur_d.z = moved ? req_q.pos_z : cur_z_q;

    batch_o.cursor              = cur_d;
    batch_o.mask[0]             = moved;
    batch_o.slot[0].kind        = pevq_pkg::EV_MOVE;
    batch_o.slot[0].anchor      = anchor_q;

    // buttons in service order; each press moves the anchor seen by later slots
    anchor_d = anchor_q;
    for (int i = 0; i < pevq_pkg::NUM_BTN; i++) begin
      if (btn[i] && !held_q[i]) begin
        act = pevq_pkg::ACT_DOWN;
        // presses inside the discard window leave the anchor alone
        if (!window) begin
          anchor_d.x = cur_d.x;
          anchor_d.y = cur_d.y;
          anchor_d.z = req_q.pos_z;
        end
      end else if (btn[i]) begin
        act = pevq_pkg::ACT_DRAG;
      end else begin
        act = pevq_pkg::ACT_UP;
      end
      batch_o.mask[i+1]        = !window && (btn[i] || held_q[i]);
      batch_o.slot[i+1].kind   = pevq_pkg::button_kind(2'(i), act);
      batch_o.slot[i+1].anchor = anchor_d;
    end

    held_d    = window ? held_q : btn;
    discard_d = window ? discard_q - 1'b1 : discard_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      cur_z_q   <= '0;
      anchor_q  <= '0;
      held_q    <= '0;
      discard_q <= DiscardW'(DISCARD_EVENTS);
    end else if (commit) begin
      cur_x_q   <= cur_d.x;
      cur_y_q   <= cur_d.y;
      cur_z_q   <= cur_d.z;
      anchor_q  <= anchor_d;
      held_q    <= held_d;
      discard_q <= discard_d;
    end
  end

  // button state is frozen while the discard window is open
  `PEVQ_ASSERT_NEXT(a_held_frozen_in_window, discard_q != '0, held_q == $past(held_q))
  // the window only counts down, one report at a time
  `PEVQ_ASSERT_SAME(a_discard_steps_down, discard_q != $past(discard_q),
                    discard_q == $past(discard_q) - 1'b1)

endmodule

`default_nettype wire

FILE: rtl/core/pevq_result_queue.sv
// ----------------------------------------------------------------------------
// pevq_result_queue
// Holds one batch of results and hands them out lowest slot first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pointer_event_qualifier_macros.svh"

module pevq_result_queue (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire pevq_pkg::batch_t         batch_i,
  output      logic                     free_o,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      pevq_pkg::event_kind_e    kind_o,
  output      pevq_pkg::point_t         cursor_o,
  output      pevq_pkg::point_t         anchor_o,
  output      logic                     last_o
);

  localparam int unsigned Slots = pevq_pkg::NUM_SLOTS;

  logic [Slots-1:0]                   mask_q;
  pevq_pkg::batch_t                   batch_q;
  logic [Slots-1:0]                   sel;
  logic [pevq_pkg::SLOT_IDX_W-1:0]    idx;
  logic [Slots-1:0]                   mask_left;
  logic                               pop;

  // lowest pending slot
  assign sel = mask_q & (~mask_q + Slots'(1));

  always_comb begin
    idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (sel[i]) idx = pevq_pkg::SLOT_IDX_W'(i);
    end
  end

  assign out_valid_o = (mask_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign mask_left   = pop ? (mask_q & ~sel) : mask_q;
  assign free_o      = (mask_left == '0);

  assign kind_o   = batch_q.slot[idx].kind;
  assign anchor_o = batch_q.slot[idx].anchor;
  assign cursor_o = batch_q.cursor;
  assign last_o   = ((mask_q & ~sel) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load_i) begin
      mask_q <= batch_i.mask;
    end else begin
      mask_q <= mask_left;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      batch_q <= batch_i;
    end
  end

  // a new batch never overwrites results still owed
  `PEVQ_ASSERT_SAME(a_load_only_when_free, load_i, free_o)
  // each taken request retires exactly one slot
  `PEVQ_ASSERT_NEXT(a_pop_retires_one, pop && !load_i,
                    $countones(mask_q) == $past($countones(mask_q)) - 1)

endmodule

`default_nettype wire

FILE: rtl/core/pointer_event_qualifier.sv
// ----------------------------------------------------------------------------
// pointer_event_qualifier
// Turns raw pointer reports into move, press, drag and release results.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pointer report per request (position, wheel, three buttons).
//   out_* : result requests; last_of_run_o marks the final result of a report.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Flow: an accepted report waits in the input register until the result queue is
//   free; it is then resolved and its results are loaded into the result queue.
// Throughput: a report holds the result queue until each of its results is
//   taken; reports producing zero or one result stream one per cycle while
//   out_ready_i is high, when the queue releases one slot per cycle and sets the rate.
// Stall: while out_ready_i is low the current result holds; one more report
//   waits in the input register and in_ready_o then drops.
// Ignored reports (ignore_pointer set) are consumed without waiting for the
//   result queue, with no results and no state change.
// Reset: cursor and anchor to zero, all buttons released, the discard window
//   reloaded to DISCARD_EVENTS reports, registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_event_qualifier #(
  parameter int unsigned DISCARD_EVENTS = pevq_pkg::DISCARD_EVENTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration writes
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [pevq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pevq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pointer reports
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic signed [15:0]                 pos_x_i,
  input  wire logic signed [15:0]                 pos_y_i,
  input  wire logic signed [15:0]                 pos_z_i,
  input  wire logic                               button_left_i,
  input  wire logic                               button_right_i,
  input  wire logic                               button_center_i,
  // results
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [3:0]                         event_kind_o,
  output      logic signed [15:0]                 cursor_x_o,
  output      logic signed [15:0]                 cursor_y_o,
  output      logic signed [15:0]                 cursor_z_o,
  output      logic signed [15:0]                 anchor_x_o,
  output      logic signed [15:0]                 anchor_y_o,
  output      logic signed [15:0]                 anchor_z_o,
  output      logic                               last_of_run_o
);

  pevq_pkg::cfg_t         cfg;
  pevq_pkg::report_t      req;
  pevq_pkg::batch_t       batch;
  pevq_pkg::event_kind_e  kind;
  pevq_pkg::point_t       cursor;
  pevq_pkg::point_t       anchor;
  logic                   free;
  logic                   load;

  assign req.pos_x         = pos_x_i;
  assign req.pos_y         = pos_y_i;
  assign req.pos_z         = pos_z_i;
  assign req.button_left   = button_left_i;
  assign req.button_right  = button_right_i;
  assign req.button_center = button_center_i;

  pevq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // resolve state and build the result batch
  pevq_engine #(
    .DISCARD_EVENTS (DISCARD_EVENTS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req),
    .free_i     (free),
    .load_o     (load),
    .batch_o    (batch)
  );

  // result register, one result per cycle while out_ready_i is high
  pevq_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .batch_i     (batch),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind),
    .cursor_o    (cursor),
    .anchor_o    (anchor),
    .last_o      (last_of_run_o)
  );

  assign event_kind_o = kind;
  assign cursor_x_o   = cursor.x;
  assign cursor_y_o   = cursor.y;
  assign cursor_z_o   = cursor.z;
  assign anchor_x_o   = anchor.x;
  assign anchor_y_o   = anchor.y;
  assign anchor_z_o   = anchor.z;

endmodule

`default_nettype wire
